### rtl/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Shared constants, types and character codes for the tab stop expander.
// ----------------------------------------------------------------------------
package tse_pkg;

   // Sizing
   localparam int STOP_ENTRIES = 64;
   localparam int COLUMN_BITS  = 12;
   localparam int PTR_W        = (STOP_ENTRIES > 1) ? $clog2(STOP_ENTRIES) : 1;
   localparam int STOP_W       = 12;    // stop_column field width
   localparam int CHAR_W       = 8;
   localparam int IDX_W        = 6;
   localparam int OUT_W        = 12;    // out_count / column_after width
   localparam int CMP_W        = (COLUMN_BITS > STOP_W) ? COLUMN_BITS : STOP_W;

   typedef logic [PTR_W-1:0]       ptr_type;
   typedef logic [COLUMN_BITS-1:0] col_type;
   typedef logic [STOP_W-1:0]      stop_type;
   typedef logic [CHAR_W-1:0]      char_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [OUT_W-1:0]       out_type;

   localparam ptr_type LAST_PTR = ptr_type'(STOP_ENTRIES - 1);
   localparam col_type COL_MAX  = '1;
   localparam col_type COL_ONE  = col_type'(1);

   // Item kinds (req_tuser)
   localparam logic ACT_CHAR  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Character codes
   localparam char_type CH_NUL   = 8'd0;
   localparam char_type CH_BS    = 8'd8;
   localparam char_type CH_TAB   = 8'd9;
   localparam char_type CH_NL    = 8'd10;
   localparam char_type CH_SPACE = 8'd32;

   // Outcome of one item: next line state plus the result beat
   typedef struct packed {
      ptr_type  ptr;
      col_type  col;
      char_type out_char;
      out_type  out_count;
   } step_result_type;

endpackage

### rtl/tse_ram.sv
// ----------------------------------------------------------------------------
// tse_ram
// Generic RAM: one write port, two registered read ports (read-old-data).
// ----------------------------------------------------------------------------
module tse_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                   wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                   rd_data_a,
   output logic [WIDTH-1:0]                   rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

### rtl/tse_stop_table.sv
// ----------------------------------------------------------------------------
// tse_stop_table
// Tab stop list: RAM plus per-entry valid bits (unwritten reads zero) and a
// write-to-read bypass. Presents entries at the pointer and pointer + 1.
// ----------------------------------------------------------------------------
module tse_stop_table import tse_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  ptr_type  wr_addr,
   input  stop_type wr_data,
   input  ptr_type  rd_addr,     // pointer value for the next cycle
   output stop_type stop_cur,    // entry at the current pointer
   output stop_type stop_nxt     // entry after it
);

   logic [STOP_ENTRIES-1:0] valid_ff;
   ptr_type  rd_addr_b;
   stop_type q_a, q_b;
   logic     vld_a_ff, vld_b_ff, byp_a_ff, byp_b_ff;
   stop_type byp_data_ff;

   assign rd_addr_b = (rd_addr == LAST_PTR) ? '0 : rd_addr + 1'b1;

   tse_ram #(
      .WIDTH (STOP_W),
      .DEPTH (STOP_ENTRIES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (q_a),
      .rd_data_b (q_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         byp_a_ff <= 1'b0;
         byp_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_a_ff <= valid_ff[rd_addr];
         vld_b_ff <= valid_ff[rd_addr_b];
         byp_a_ff <= wr_en && (wr_addr == rd_addr);
         byp_b_ff <= wr_en && (wr_addr == rd_addr_b);
      end
      byp_data_ff <= wr_data;
   end

   assign stop_cur = byp_a_ff ? byp_data_ff : (vld_a_ff ? q_a : '0);
   assign stop_nxt = byp_b_ff ? byp_data_ff : (vld_b_ff ? q_b : '0);

endmodule

### rtl/tse_step.sv
// ----------------------------------------------------------------------------
// tse_step
// Per-item line logic: pointer advance, tab / backspace / pass-through, and
// the next column and pointer.
// ----------------------------------------------------------------------------
module tse_step import tse_pkg::*; (
   input  logic            is_write,
   input  char_type        char_code,
   input  col_type         col,
   input  ptr_type         ptr,
   input  stop_type        stop_cur,
   input  stop_type        stop_nxt,
   output step_result_type res
);

   localparam logic [CMP_W-1:0] COL_MAX_W = CMP_W'(COL_MAX);

   logic [CMP_W-1:0] col_w, s0_w, cs_w, target_w;
   logic     fwd1;
   ptr_type  ptr1;
   stop_type cs;
   col_type  col_dec, target;

   always_comb begin
      col_w = CMP_W'(col);
      s0_w  = CMP_W'(stop_cur);

      // pre-advance: one step when the column has reached the stop
      fwd1 = (col_w >= s0_w) && (stop_cur != '0) && (ptr != LAST_PTR);
      ptr1 = fwd1 ? ptr + 1'b1 : ptr;
      cs   = fwd1 ? stop_nxt : stop_cur;
      cs_w = CMP_W'(cs);

      target_w = (cs_w > COL_MAX_W) ? COL_MAX_W : cs_w;
      target   = COLUMN_BITS'(target_w);
      col_dec  = (col > COL_ONE) ? col - 1'b1 : col;

      res = '{ptr: ptr, col: col, out_char: CH_NUL, out_count: '0};

      if (!is_write) begin
         case (char_code)
            CH_BS: begin
               res.col       = col_dec;
               res.out_char  = CH_BS;
               res.out_count = out_type'(1);
               res.ptr       = ((CMP_W'(col_dec) < cs_w) && (ptr1 != '0)) ?
                               ptr1 - 1'b1 : ptr1;
            end
            CH_TAB: begin
               res.out_char = CH_SPACE;
               if (col < target) begin
                  res.out_count = OUT_W'(target - col);
                  res.col       = target;
               end
               res.ptr = ((cs != '0) && (ptr1 != LAST_PTR)) ? ptr1 + 1'b1 : ptr1;
            end
            CH_NL: begin
               res.out_char  = CH_NL;
               res.out_count = out_type'(1);
               res.col       = COL_ONE;
               res.ptr       = '0;
            end
            default: begin
               res.out_char  = char_code;
               res.out_count = out_type'(1);
               res.col       = (col != COL_MAX) ? col + 1'b1 : col;
               res.ptr       = ptr1;
            end
         endcase
      end
   end

endmodule

### rtl/tab_stop_expander_unit.sv
// ----------------------------------------------------------------------------
// tab_stop_expander_unit
// Tab expander over a loadable list of tab stop columns, stream in and out.
// ----------------------------------------------------------------------------
// The accepting edge loads the input register; the edge on which the stage
//   fires loads the result register and raises rsp_tvalid.
// Throughput: one beat per cycle unless the response channel stalls; set by
//   the loop from the stop table read through the step compare back into the table read address.
// Reset: column 1, pointer 0, pipeline empty; the stop list reads all zero
//   at once through per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module tab_stop_expander_unit import tse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // char_code[7:0], stop_index[13:8],
                                    // stop_column[25:14], zero[31:26]
   input  logic        req_tuser,   // action: 0 character, 1 table write
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // out_char[7:0], out_count[19:8],
                                    // column_after[31:20]
);

   // input register
   logic     item_valid_ff;
   logic     item_action_ff;
   char_type item_char_ff;
   idx_type  item_idx_ff;
   stop_type item_stop_ff;

   // line state
   col_type  col_ff;
   ptr_type  ptr_ff;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic            fire, accept, wr_en, idx_ok;
   ptr_type         rd_addr;
   stop_type        stop_cur, stop_nxt;
   step_result_type res;

   // stage moves when the result slot is free or being drained
   assign fire       = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   // table write beats outside the list are dropped
   assign idx_ok = 32'(item_idx_ff) < STOP_ENTRIES;
   assign wr_en  = fire && (item_action_ff == ACT_WRITE) && idx_ok;

   // table read runs one pointer ahead: the next pointer addresses the RAM
   assign rd_addr = fire ? res.ptr : ptr_ff;

   tse_stop_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (PTR_W'(item_idx_ff)),
      .wr_data  (item_stop_ff),
      .rd_addr  (rd_addr),
      .stop_cur (stop_cur),
      .stop_nxt (stop_nxt)
   );

   tse_step u_step (
      .is_write  (item_action_ff == ACT_WRITE),
      .char_code (item_char_ff),
      .col       (col_ff),
      .ptr       (ptr_ff),
      .stop_cur  (stop_cur),
      .stop_nxt  (stop_nxt),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         col_ff        <= COL_ONE;
         ptr_ff        <= '0;
      end else begin
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (fire) begin
            item_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            col_ff       <= res.col;
            ptr_ff       <= res.ptr;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // payload, no reset
      if (accept) begin
         item_action_ff <= req_tuser;
         item_char_ff   <= req_tdata[7:0];
         item_idx_ff    <= req_tdata[13:8];
         item_stop_ff   <= req_tdata[25:14];
      end
      if (fire) begin
         rsp_data_ff <= {OUT_W'(res.col), res.out_count, res.out_char};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // column never drops below 1
   a_col_nonzero: assert property (@(posedge clock) disable iff (reset)
      col_ff != '0)
      else $error("column reached zero");

   // a stalled stage leaves the line state alone
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> (col_ff == $past(col_ff)) && (ptr_ff == $past(ptr_ff)))
      else $error("line state moved without a beat");

   // newline returns the line to its start
   a_newline: assert property (@(posedge clock) disable iff (reset)
      fire && (item_action_ff == ACT_CHAR) && (item_char_ff == CH_NL)
      |=> (col_ff == COL_ONE) && (ptr_ff == '0))
      else $error("newline did not reset the line");

   // table writes never touch the line state
   a_write_keeps: assert property (@(posedge clock) disable iff (reset)
      fire && (item_action_ff == ACT_WRITE)
      |=> (col_ff == $past(col_ff)) && (ptr_ff == $past(ptr_ff)))
      else $error("table write changed line state");
`endif

endmodule
